[rtl/fpl_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// fpl_pkg: shared types and constants of the five-point Laplacian stream
// Field widths of the register file and the result channel, register indexes,
// and the tag that travels with each result through the arithmetic pipeline.
// ============================================================================
package fpl_pkg;

    // Register file widths
    localparam int CFG_DIM_W = 11;
    localparam int SCALE_W   = 16;

    // Result channel widths
    localparam int LAP_W   = 28;
    localparam int COORD_W = 10;

    // Register reset values
    localparam logic [CFG_DIM_W-1:0] GRID_DIM_RESET = 11'd1024;
    localparam logic [SCALE_W-1:0]   SCALE_RESET    = 16'd256;

    // Register indexes of the write port
    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_INV_DX_SQ   = 2'd2,
        REG_INV_DY_SQ   = 2'd3
    } t_reg_idx;

    // Position and frame marker of one result
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } t_res_tag;

endpackage

[rtl/fpl_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// fpl_ram: generic dual-read single-write synchronous RAM
// One write port and two read ports; read data is registered and holds while
// the read enable is low.
// ============================================================================
module fpl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                            o_rdata_a,
    output logic [WIDTH-1:0]                            o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/fpl_line_buf.sv]
`timescale 1ns / 1ps
// ============================================================================
// fpl_line_buf: raster counters, line stores and stencil operand selection
// Reads both line stores per accepted sample and updates them as it leaves
// stage one; up to three stencil requests per sample, one per ready cycle.
// ============================================================================
module fpl_line_buf
    import fpl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    // effective grid size
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]    i_grid_w,
    input  logic [$clog2(MAX_HEIGHT + 1)-1:0]   i_grid_h,
    // stencil request to the arithmetic unit
    output logic                                o_req_valid,
    input  logic                                i_req_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_left,
    output logic signed [SAMPLE_BITS-1:0]       o_centre,
    output logic signed [SAMPLE_BITS-1:0]       o_right,
    output logic signed [SAMPLE_BITS-1:0]       o_up,
    output logic signed [SAMPLE_BITS-1:0]       o_down,
    output t_res_tag                            o_tag
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Pending result codes, lowest bit served first
    localparam logic [2:0] PICK_ABOVE  = 3'b001;
    localparam logic [2:0] PICK_BEHIND = 3'b010;
    localparam logic [2:0] PICK_FINAL  = 3'b100;

    typedef struct packed {
        logic has_left;
        logic left2;
        logic has_right;
        logic up1;
        logic up2;
    } t_pt_flags;

    // Raster position and recent samples
    logic [CW-1:0]                 r_col;
    logic [RW-1:0]                 r_row;
    logic signed [SAMPLE_BITS-1:0] r_rec0;
    logic signed [SAMPLE_BITS-1:0] r_rec1;

    // Stage one: sample waiting for its store data
    logic                          r_s1_valid;
    logic [2:0]                    r_s1_pend;
    t_pt_flags                     r_s1_flags;
    logic [CW-1:0]                 r_s1_col;
    logic [RW-1:0]                 r_s1_row;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic signed [SAMPLE_BITS-1:0] r_s1_rec0;
    logic signed [SAMPLE_BITS-1:0] r_s1_rec1;

    // Last store write, for forwarding
    logic                          r_wb_valid;
    logic [CW-1:0]                 r_wb_addr;
    logic signed [SAMPLE_BITS-1:0] r_wb_p;
    logic signed [SAMPLE_BITS-1:0] r_wb_o;

    logic                          accept;
    logic [CW-1:0]                 cur_col;
    logic [RW-1:0]                 cur_row;
    logic                          last_col;
    logic                          last_row;
    t_pt_flags                     new_flags;
    logic [2:0]                    new_pend;

    logic [2:0]                    pick;
    logic                          take;
    logic [2:0]                    pend_left;
    logic                          s1_leave;

    logic [SAMPLE_BITS-1:0]        p_rd_a;
    logic [SAMPLE_BITS-1:0]        p_rd_b;
    logic [SAMPLE_BITS-1:0]        o_rd_a;
    logic [SAMPLE_BITS-1:0]        o_rd_b;
    logic [CW-1:0]                 s1_col_p1;
    logic [CW-1:0]                 s1_col_m1;
    logic signed [SAMPLE_BITS-1:0] pc;
    logic signed [SAMPLE_BITS-1:0] pc1;
    logic signed [SAMPLE_BITS-1:0] ocm1;
    logic signed [SAMPLE_BITS-1:0] oc;

    // Clamp the raster position to the current grid size
    always_comb begin
        cur_col  = (r_col >= i_grid_w) ? CW'(i_grid_w - 1'b1) : r_col;
        cur_row  = (r_row >= i_grid_h) ? RW'(i_grid_h - 1'b1) : r_row;
        last_col = (cur_col == (i_grid_w - 1'b1));
        last_row = (cur_row == (i_grid_h - 1'b1));

        new_flags.has_left  = (cur_col != '0);
        new_flags.left2     = (cur_col > CW'(1));
        new_flags.has_right = !last_col;
        new_flags.up1       = (cur_row != '0);
        new_flags.up2       = (cur_row > RW'(1));

        new_pend = {last_row && last_col, last_row && (cur_col != '0), cur_row != '0};
    end

    // Serve pending requests lowest first; leave once none remain
    assign pick        = r_s1_pend & (~r_s1_pend + 3'd1);
    assign o_req_valid = r_s1_valid && (r_s1_pend != '0);
    assign take        = o_req_valid && i_req_ready;
    assign pend_left   = take ? (r_s1_pend & ~pick) : r_s1_pend;
    assign s1_leave    = r_s1_valid && (pend_left == '0);
    assign o_stall     = r_s1_valid && !s1_leave;
    assign accept      = i_valid && !o_stall;

    // Line stores: previous row and the row before it
    fpl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_prev_row (
        .i_clk     (i_clk),
        .i_we      (s1_leave),
        .i_waddr   (r_s1_col),
        .i_wdata   (r_s1_sample),
        .i_re      (accept),
        .i_raddr_a (cur_col),
        .i_raddr_b (CW'(cur_col + 1'b1)),
        .o_rdata_a (p_rd_a),
        .o_rdata_b (p_rd_b)
    );

    fpl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_older_row (
        .i_clk     (i_clk),
        .i_we      (s1_leave),
        .i_waddr   (r_s1_col),
        .i_wdata   (pc),
        .i_re      (accept),
        .i_raddr_a (CW'(cur_col - 1'b1)),
        .i_raddr_b (cur_col),
        .o_rdata_a (o_rd_a),
        .o_rdata_b (o_rd_b)
    );

    // Forward the write that landed on the same edge as the read
    always_comb begin
        s1_col_p1 = CW'(r_s1_col + 1'b1);
        s1_col_m1 = CW'(r_s1_col - 1'b1);
        pc   = (r_wb_valid && (r_wb_addr == r_s1_col))  ? r_wb_p : $signed(p_rd_a);
        pc1  = (r_wb_valid && (r_wb_addr == s1_col_p1)) ? r_wb_p : $signed(p_rd_b);
        ocm1 = (r_wb_valid && (r_wb_addr == s1_col_m1)) ? r_wb_o : $signed(o_rd_a);
        oc   = (r_wb_valid && (r_wb_addr == r_s1_col))  ? r_wb_o : $signed(o_rd_b);
    end

    // Select stencil operands for the request being served
    always_comb begin
        o_centre = r_s1_sample;
        o_left   = r_s1_sample;
        o_right  = r_s1_sample;
        o_up     = r_s1_sample;
        o_down   = r_s1_sample;
        o_tag    = '0;
        unique case (pick)
            PICK_ABOVE: begin
                // point one row up, this sample is its lower neighbor
                o_centre = pc;
                o_left   = r_s1_flags.has_left  ? ocm1 : pc;
                o_right  = r_s1_flags.has_right ? pc1  : pc;
                o_up     = r_s1_flags.up2       ? oc   : pc;
                o_down   = r_s1_sample;
                o_tag.col  = COORD_W'(r_s1_col);
                o_tag.row  = COORD_W'(RW'(r_s1_row - 1'b1));
                o_tag.last = 1'b0;
            end
            PICK_BEHIND: begin
                // point one column back on the bottom row
                o_centre = r_s1_rec0;
                o_left   = r_s1_flags.left2 ? r_s1_rec1 : r_s1_rec0;
                o_right  = r_s1_sample;
                o_up     = r_s1_flags.up1   ? ocm1      : r_s1_rec0;
                o_down   = r_s1_rec0;
                o_tag.col  = COORD_W'(s1_col_m1);
                o_tag.row  = COORD_W'(r_s1_row);
                o_tag.last = 1'b0;
            end
            PICK_FINAL: begin
                // bottom right corner of the frame
                o_centre = r_s1_sample;
                o_left   = r_s1_flags.has_left ? r_s1_rec0 : r_s1_sample;
                o_right  = r_s1_sample;
                o_up     = r_s1_flags.up1      ? pc        : r_s1_sample;
                o_down   = r_s1_sample;
                o_tag.col  = COORD_W'(r_s1_col);
                o_tag.row  = COORD_W'(r_s1_row);
                o_tag.last = 1'b1;
            end
            default: begin
                o_tag = '0;
            end
        endcase
    end

    // Advance raster position and stage one; record the store write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_rec0     <= '0;
            r_rec1     <= '0;
            r_s1_valid <= 1'b0;
            r_s1_pend  <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            if (s1_leave) begin
                r_wb_valid <= 1'b1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_s1_pend  <= new_pend;
                r_rec0     <= i_sample;
                r_rec1     <= r_rec0;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : RW'(cur_row + 1'b1);
                end else begin
                    r_col <= CW'(cur_col + 1'b1);
                    r_row <= cur_row;
                end
            end else begin
                r_s1_valid <= r_s1_valid && !s1_leave;
                r_s1_pend  <= pend_left;
            end
        end
    end

    // Payload of stage one and the forwarding register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flags  <= new_flags;
            r_s1_col    <= cur_col;
            r_s1_row    <= cur_row;
            r_s1_sample <= i_sample;
            r_s1_rec0   <= r_rec0;
            r_s1_rec1   <= r_rec1;
        end
        if (s1_leave) begin
            r_wb_addr <= r_s1_col;
            r_wb_p    <= r_s1_sample;
            r_wb_o    <= pc;
        end
    end

endmodule

[rtl/fpl_lap_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// fpl_lap_unit: three-stage Laplacian arithmetic pipeline
// Second differences, Q8.8 scaling products, then sum and floor shift by 8
// into the output register.
// ============================================================================
module fpl_lap_unit
    import fpl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_centre,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    input  logic signed [SAMPLE_BITS-1:0] i_up,
    input  logic signed [SAMPLE_BITS-1:0] i_down,
    input  t_res_tag                      i_tag,
    input  logic [SCALE_W-1:0]            i_inv_dx_sq,
    input  logic [SCALE_W-1:0]            i_inv_dy_sq,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [LAP_W-1:0]       o_laplace_value,
    output t_res_tag                      o_tag
);

    localparam int DW = SAMPLE_BITS + 2;
    localparam int PW = DW + SCALE_W + 1;
    localparam int SW = PW + 1;

    logic                 r_a_valid;
    logic signed [DW-1:0] r_a_h;
    logic signed [DW-1:0] r_a_v;
    t_res_tag             r_a_tag;

    logic                 r_b_valid;
    logic signed [PW-1:0] r_b_ph;
    logic signed [PW-1:0] r_b_pv;
    t_res_tag             r_b_tag;

    logic                    r_c_valid;
    logic signed [LAP_W-1:0] r_c_val;
    t_res_tag                r_c_tag;

    logic                 rdy_a;
    logic                 rdy_b;
    logic                 rdy_c;
    logic signed [DW-1:0] hdiff;
    logic signed [DW-1:0] vdiff;
    logic signed [PW-1:0] ph;
    logic signed [PW-1:0] pv;
    logic signed [SW-1:0] sum;

    // Each stage moves when it is empty or the next one moves
    assign rdy_c       = !r_c_valid || !i_stall;
    assign rdy_b       = !r_b_valid || rdy_c;
    assign rdy_a       = !r_a_valid || rdy_b;
    assign o_req_ready = rdy_a;

    // Second differences
    assign hdiff = DW'(i_left) + DW'(i_right) - (DW'(i_centre) <<< 1);
    assign vdiff = DW'(i_up) + DW'(i_down) - (DW'(i_centre) <<< 1);

    // Scale by the Q8.8 reciprocals
    assign ph = PW'(r_a_h) * $signed(PW'({1'b0, i_inv_dx_sq}));
    assign pv = PW'(r_a_v) * $signed(PW'({1'b0, i_inv_dy_sq}));

    // Sum and floor shift
    assign sum = SW'(r_b_ph) + SW'(r_b_pv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_valid <= i_req_valid;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_h   <= hdiff;
            r_a_v   <= vdiff;
            r_a_tag <= i_tag;
        end
        if (rdy_b) begin
            r_b_ph  <= ph;
            r_b_pv  <= pv;
            r_b_tag <= r_a_tag;
        end
        if (rdy_c) begin
            r_c_val <= LAP_W'(sum >>> 8);
            r_c_tag <= r_b_tag;
        end
    end

    assign o_valid         = r_c_valid;
    assign o_laplace_value = r_c_val;
    assign o_tag           = r_c_tag;

endmodule

[rtl/five_point_laplacian_stream_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// five_point_laplacian_stream_core: streaming five-point Laplacian
// Takes grid samples in raster order and emits the scaled five-point Laplacian
// of every grid point with replicated borders, tagged with column and row.
// ============================================================================
// Samples are taken one per clock unless stalled. Point (c, r-1) is produced
// when sample (c, r) arrives, so results trail the input by one row; the
// bottom row is produced as its samples stream in. All results leave through
// one output register at one per clock unless the output stalls, and a sample
// that causes several results holds the input until its requests are taken:
// up to two on the last row and up to three on the final sample of a frame,
// while every other row runs at one sample per cycle. A result passes from
// stage one through the difference, product and output registers in turn.
// The two line stores are single-write dual-read RAMs of MAX_WIDTH entries;
// they need no clearing pass after reset. Write registers only while the
// block is idle: grid_width (0), grid_height (1), inv_dx_sq (2), inv_dy_sq (3).
// ============================================================================
module five_point_laplacian_stream_core
    import fpl_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [SCALE_W-1:0]            i_cfg_data,
    // sample channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [LAP_W-1:0]       o_laplace_value,
    output logic [COORD_W-1:0]            o_out_col,
    output logic [COORD_W-1:0]            o_out_row,
    output logic                          o_frame_last
);

    localparam int WEW = $clog2(MAX_WIDTH + 1);
    localparam int HEW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_DIM_W-1:0] r_grid_width;
    logic [CFG_DIM_W-1:0] r_grid_height;
    logic [SCALE_W-1:0]   r_inv_dx_sq;
    logic [SCALE_W-1:0]   r_inv_dy_sq;

    logic [WEW-1:0] grid_w;
    logic [HEW-1:0] grid_h;

    logic                          req_valid;
    logic                          req_ready;
    logic signed [SAMPLE_BITS-1:0] op_left;
    logic signed [SAMPLE_BITS-1:0] op_centre;
    logic signed [SAMPLE_BITS-1:0] op_right;
    logic signed [SAMPLE_BITS-1:0] op_up;
    logic signed [SAMPLE_BITS-1:0] op_down;
    t_res_tag                      req_tag;
    t_res_tag                      res_tag;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_DIM_RESET;
            r_grid_height <= GRID_DIM_RESET;
            r_inv_dx_sq   <= SCALE_RESET;
            r_inv_dy_sq   <= SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[CFG_DIM_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data[CFG_DIM_W-1:0];
                REG_INV_DX_SQ:   r_inv_dx_sq   <= i_cfg_data;
                REG_INV_DY_SQ:   r_inv_dy_sq   <= i_cfg_data;
            endcase
        end
    end

    // Clamp grid size to 1..maximum
    always_comb begin
        if (r_grid_width == '0) begin
            grid_w = WEW'(1);
        end else if (r_grid_width > MAX_WIDTH) begin
            grid_w = WEW'(MAX_WIDTH);
        end else begin
            grid_w = WEW'(r_grid_width);
        end
        if (r_grid_height == '0) begin
            grid_h = HEW'(1);
        end else if (r_grid_height > MAX_HEIGHT) begin
            grid_h = HEW'(MAX_HEIGHT);
        end else begin
            grid_h = HEW'(r_grid_height);
        end
    end

    fpl_line_buf #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT)
    ) u_line_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .i_grid_w    (grid_w),
        .i_grid_h    (grid_h),
        .o_req_valid (req_valid),
        .i_req_ready (req_ready),
        .o_left      (op_left),
        .o_centre    (op_centre),
        .o_right     (op_right),
        .o_up        (op_up),
        .o_down      (op_down),
        .o_tag       (req_tag)
    );

    fpl_lap_unit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lap_unit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_valid),
        .o_req_ready     (req_ready),
        .i_left          (op_left),
        .i_centre        (op_centre),
        .i_right         (op_right),
        .i_up            (op_up),
        .i_down          (op_down),
        .i_tag           (req_tag),
        .i_inv_dx_sq     (r_inv_dx_sq),
        .i_inv_dy_sq     (r_inv_dy_sq),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_laplace_value (o_laplace_value),
        .o_tag           (res_tag)
    );

    assign o_out_col    = res_tag.col;
    assign o_out_row    = res_tag.row;
    assign o_frame_last = res_tag.last;

endmodule

[verif/five_point_laplacian_stream_core_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// five_point_laplacian_stream_core_tb: self-checking bench of the Laplacian stream
// Streams grid samples through the core with random gaps and stalls on both
// channels. A behavioral copy of the stencil and the line stores predicts every
// result, and each result is checked field by field in arrival order.
// ============================================================================
module five_point_laplacian_stream_core_tb
    import fpl_pkg::*;
();

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    typedef struct {
        logic signed [LAP_W-1:0] value;
        logic [COORD_W-1:0]      col;
        logic [COORD_W-1:0]      row;
        logic                    last;
    } t_lap_result;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [1:0]              i_cfg_index = 2'd0;
    logic [SCALE_W-1:0]      i_cfg_data  = '0;
    logic                    i_valid     = 1'b0;
    logic                    o_stall;
    logic signed [15:0]      i_sample    = '0;
    logic                    o_valid;
    logic                    i_stall     = 1'b0;
    logic signed [LAP_W-1:0] o_laplace_value;
    logic [COORD_W-1:0]      o_out_col;
    logic [COORD_W-1:0]      o_out_row;
    logic                    o_frame_last;

    // Shadow registers and stencil state
    logic [CFG_DIM_W-1:0] grid_w_reg = GRID_DIM_RESET;
    logic [CFG_DIM_W-1:0] grid_h_reg = GRID_DIM_RESET;
    logic [SCALE_W-1:0]   kx_reg     = SCALE_RESET;
    logic [SCALE_W-1:0]   ky_reg     = SCALE_RESET;
    logic signed [15:0]   prev_row  [MAX_COLS] = '{default: '0};
    logic signed [15:0]   older_row [MAX_COLS] = '{default: '0};
    logic signed [15:0]   recent0 = '0;
    logic signed [15:0]   recent1 = '0;
    int                   col_pos = 0;
    int                   row_pos = 0;

    t_lap_result lap_expect_q[$];
    int          err_count    = 0;
    int          samples_sent = 0;
    int          gap_pct      = 20;
    int          stall_pct    = 20;
    int          stall_hold   = 0;

    five_point_laplacian_stream_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_laplace_value (o_laplace_value),
        .o_out_col       (o_out_col),
        .o_out_row       (o_out_row),
        .o_frame_last    (o_frame_last)
    );

    always #5 i_clk = ~i_clk;

    // Mostly zero, sometimes a short hold, rarely a long one
    function automatic int pick_delay(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] random_scale();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // Scaled second differences, floor shift by 8
    function automatic longint scaled_lap(input longint lft, input longint cen,
                                          input longint rgt, input longint up,
                                          input longint down);
        longint hd;
        longint vd;
        longint kx;
        longint ky;
        hd = lft + rgt - 2 * cen;
        vd = up + down - 2 * cen;
        kx = kx_reg;
        ky = ky_reg;
        return (hd * kx + vd * ky) >>> 8;
    endfunction

    function automatic void push_result(input longint v, input int c, input int r,
                                        input logic last);
        t_lap_result res;
        res.value = v[LAP_W-1:0];
        res.col   = c[COORD_W-1:0];
        res.row   = r[COORD_W-1:0];
        res.last  = last;
        lap_expect_q = {lap_expect_q, res};
    endfunction

    // Advance the stencil by one accepted sample and queue the points it completes
    function automatic void stencil_step(input logic signed [15:0] s);
        int     w;
        int     h;
        int     c;
        int     r;
        longint cen;
        longint lft;
        longint rgt;
        longint up;
        logic   last_row;
        w = (grid_w_reg == 0) ? 1 : int'(grid_w_reg);
        h = (grid_h_reg == 0) ? 1 : int'(grid_h_reg);
        if (w > MAX_COLS) w = MAX_COLS;
        if (h > MAX_ROWS) h = MAX_ROWS;
        // saturate counters after a size reduction
        if (col_pos >= w) col_pos = w - 1;
        if (row_pos >= h) row_pos = h - 1;
        c = col_pos;
        r = row_pos;

        // point one row above the incoming sample
        if (r >= 1) begin
            cen = prev_row[c];
            lft = (c > 0) ? older_row[c - 1] : cen;
            rgt = (c + 1 < w) ? prev_row[c + 1] : cen;
            up  = (r >= 2) ? older_row[c] : cen;
            push_result(scaled_lap(lft, cen, rgt, up, s), c, r - 1, 1'b0);
        end

        // bottom row: left neighbor point, then the frame corner
        last_row = (r == h - 1);
        if (last_row && c >= 1) begin
            cen = recent0;
            lft = (c >= 2) ? recent1 : cen;
            up  = (r >= 1) ? older_row[c - 1] : cen;
            push_result(scaled_lap(lft, cen, s, up, cen), c - 1, r, 1'b0);
        end
        if (last_row && c == w - 1) begin
            lft = (c >= 1) ? recent0 : s;
            up  = (r >= 1) ? prev_row[c] : s;
            push_result(scaled_lap(lft, s, s, up, s), c, r, 1'b1);
        end

        older_row[c] = prev_row[c];
        prev_row[c]  = s;
        recent1      = recent0;
        recent0      = s;
        if (c >= w - 1) begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    task automatic note_error(input string msg);
        if (err_count < 10) $display("%s", msg);
        err_count++;
    endtask

    // Check each accepted result against the oldest prediction, then pick the next stall
    always @(posedge i_clk) begin
        t_lap_result want;
        int          d;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (lap_expect_q.size() == 0) begin
                note_error($sformatf("unexpected result: value %0d col %0d row %0d last %0b",
                                     o_laplace_value, o_out_col, o_out_row, o_frame_last));
            end else begin
                want = lap_expect_q.pop_front();
                if (o_laplace_value !== want.value || o_out_col !== want.col ||
                    o_out_row !== want.row || o_frame_last !== want.last) begin
                    note_error($sformatf({"mismatch: expected value %0d col %0d row %0d ",
                                          "last %0b, got value %0d col %0d row %0d last %0b"},
                                         want.value, want.col, want.row, want.last,
                                         o_laplace_value, o_out_col, o_out_row,
                                         o_frame_last));
                end
            end
        end
        if (stall_hold > 0) begin
            stall_hold--;
            i_stall <= 1'b1;
        end else begin
            d = pick_delay(stall_pct);
            if (d > 0) begin
                stall_hold = d - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Send one sample request and hold it until accepted
    task automatic send_sample(input logic signed [15:0] s);
        int gap;
        gap = pick_delay(gap_pct);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        stencil_step(s);
        samples_sent++;
    endtask

    // Drop the request line and let every predicted result come out
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (lap_expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [SCALE_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_GRID_WIDTH:  grid_w_reg = data[CFG_DIM_W-1:0];
            REG_GRID_HEIGHT: grid_h_reg = data[CFG_DIM_W-1:0];
            REG_INV_DX_SQ:   kx_reg = data;
            REG_INV_DY_SQ:   ky_reg = data;
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [SCALE_W-1:0] w, input logic [SCALE_W-1:0] h,
                            input logic [SCALE_W-1:0] kx, input logic [SCALE_W-1:0] ky);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_INV_DX_SQ, kx);
        write_reg(REG_INV_DY_SQ, ky);
    endtask

    // Stream random samples up to the end of the current frame
    task automatic finish_frame();
        do begin
            send_sample(random_sample());
        end while (col_pos != 0 || row_pos != 0);
    endtask

    // Zero sizes fold to a single point; every sample is its own frame
    task automatic test_unit_grid();
        wait_idle();
        set_grid(16'd0, 16'd0, 16'hFFFF, 16'd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
    endtask

    // Full-scale checkerboard at maximum gain for the widest differences
    task automatic test_checkerboard();
        wait_idle();
        set_grid(16'd3, 16'd3, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < 9; k++) begin
            send_sample((k % 2 == 0) ? 16'sh7FFF : 16'sh8000);
        end
    endtask

    // One row, then one column, so only one direction has neighbors
    task automatic test_row_and_column();
        wait_idle();
        set_grid(16'd5, 16'd1, 16'd256, 16'hFFFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        send_sample(16'sh8000);
        wait_idle();
        set_grid(16'd5, 16'd5, 16'd0, 16'd256);
        write_reg(REG_GRID_WIDTH, 16'd1);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh1234);
        send_sample(16'shEDCB);
        send_sample(16'sh7FFF);
    endtask

    // Oversized registers clamp to the maximum; shrinking mid frame saturates counters
    task automatic test_size_clamp();
        wait_idle();
        set_grid(16'hFFFF, 16'hF7FF, random_scale(), random_scale());
        repeat (20) send_sample(random_sample());
        wait_idle();
        write_reg(REG_GRID_WIDTH, 16'd6);
        write_reg(REG_GRID_HEIGHT, 16'd4);
        finish_frame();
        wait_idle();
        set_grid(16'd5, 16'd5, random_scale(), random_scale());
        repeat (17) send_sample(random_sample());
        wait_idle();
        write_reg(REG_GRID_HEIGHT, 16'd2);
        finish_frame();
    endtask

    // Random frames with random sizes, gains and idling patterns
    task automatic test_random_frames();
        int stop_at;
        int w;
        int h;
        stop_at = samples_sent + 100;
        while (samples_sent < stop_at) begin
            gap_pct   = (($urandom_range(2) == 0) ? 0 : $urandom_range(50, 5));
            stall_pct = (($urandom_range(2) == 0) ? 0 : $urandom_range(50, 5));
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(9))
                    0:       w = 1;
                    1:       w = 2;
                    8, 9:    w = $urandom_range(40, 11);
                    default: w = $urandom_range(10, 3);
                endcase
                h = ($urandom_range(4) == 0) ? 1 : $urandom_range(6, 2);
                wait_idle();
                set_grid({5'($urandom_range(31)), 11'(w)}, {5'($urandom_range(31)), 11'(h)},
                         random_scale(), random_scale());
            end
            finish_frame();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_unit_grid();
        test_checkerboard();
        test_row_and_column();
        test_size_clamp();
        test_random_frames();
        wait_idle();
        if (err_count == 0) begin
            $display("five_point_laplacian_stream_core_tb passed");
        end else begin
            $display("five_point_laplacian_stream_core_tb failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #(5_000_000);
        $display("five_point_laplacian_stream_core_tb failed");
        $finish;
    end

endmodule
